@@ design/sct_pkg.sv @@
// Shared types, constants and classification functions for the S-expression tokenizer.
package sct_pkg;

   localparam int unsigned MaxTokenLen = 255;
   localparam int unsigned MaxPosition = 65535;

   localparam logic [3:0] K_LPAREN   = 4'd0;
   localparam logic [3:0] K_RPAREN   = 4'd1;
   localparam logic [3:0] K_INT      = 4'd2;
   localparam logic [3:0] K_STRING   = 4'd3;
   localparam logic [3:0] K_DOT      = 4'd4;
   localparam logic [3:0] K_FLOAT    = 4'd5;
   localparam logic [3:0] K_NIL      = 4'd6;
   localparam logic [3:0] K_TRUE     = 4'd7;
   localparam logic [3:0] K_QUOTE    = 4'd8;
   localparam logic [3:0] K_SYMBOL   = 4'd9;
   localparam logic [3:0] K_EOF      = 4'd10;
   localparam logic [3:0] K_UNCLOSED = 4'd11;

   localparam logic [3:0] C_START   = 4'd0;
   localparam logic [3:0] C_SIGN    = 4'd1;
   localparam logic [3:0] C_INT     = 4'd2;
   localparam logic [3:0] C_DOT     = 4'd3;
   localparam logic [3:0] C_SIGNDOT = 4'd4;
   localparam logic [3:0] C_INTDOT  = 4'd5;
   localparam logic [3:0] C_FRAC    = 4'd6;
   localparam logic [3:0] C_FEND    = 4'd7;
   localparam logic [3:0] C_LT      = 4'd8;
   localparam logic [3:0] C_HASH    = 4'd9;
   localparam logic [3:0] C_HT      = 4'd10;
   localparam logic [3:0] C_HF      = 4'd11;
   localparam logic [3:0] C_N1      = 4'd12;
   localparam logic [3:0] C_N2      = 4'd13;
   localparam logic [3:0] C_N3      = 4'd14;
   localparam logic [3:0] C_OTHER   = 4'd15;

   typedef struct packed {
      logic       eoi;
      logic       blank;
      logic       newline;
      logic       semi;
      logic       lparen;
      logic       rparen;
      logic       dquote;
      logic       squote;
      logic       bslash;
      logic [7:0] ch;
   } char_class_type;

   function automatic logic [3:0] cls_next(input logic [3:0] s, input logic [7:0] c);
      logic dig;
      logic [3:0] r;
      dig = (c >= 8'h30) && (c <= 8'h39);
      r = C_OTHER;
      case (s)
         C_START: begin
            if (dig) r = C_INT;
            else if (c == 8'h2B || c == 8'h2D) r = C_SIGN;
            else if (c == 8'h2E) r = C_DOT;
            else if (c == 8'h74) r = C_LT;
            else if (c == 8'h23) r = C_HASH;
            else if (c == 8'h6E) r = C_N1;
         end
         C_SIGN: begin
            if (dig) r = C_INT;
            else if (c == 8'h2E) r = C_SIGNDOT;
         end
         C_INT: begin
            if (dig) r = C_INT;
            else if (c == 8'h2E) r = C_INTDOT;
         end
         C_DOT, C_SIGNDOT, C_INTDOT, C_FRAC: begin
            if (dig) r = C_FRAC;
            else if (c == 8'h66) r = C_FEND;
         end
         C_HASH: begin
            if (c == 8'h74) r = C_HT;
            else if (c == 8'h66) r = C_HF;
         end
         C_N1: if (c == 8'h69) r = C_N2;
         C_N2: if (c == 8'h6C) r = C_N3;
         default: r = C_OTHER;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] cls_kind(input logic [3:0] s);
      logic [3:0] k;
      case (s)
         C_DOT: k = K_DOT;
         C_LT, C_HT: k = K_TRUE;
         C_HF, C_N3: k = K_NIL;
         C_INT: k = K_INT;
         C_INTDOT, C_FRAC, C_FEND: k = K_FLOAT;
         default: k = K_SYMBOL;
      endcase
      return k;
   endfunction

endpackage

@@ design/sct_front.sv @@
// Input stage: accepts an item, classifies the character and registers it.
module sct_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_input_byte,
   input  logic                    req_end_of_input,
   output logic                    cls_valid,
   output sct_pkg::char_class_type cls_item,
   input  logic                    cls_stall
);
   import sct_pkg::*;

   logic           valid_ff, valid_in;
   char_class_type item_ff, item_in;
   logic           take;

   assign req_stall = valid_ff && cls_stall;
   assign take      = req_valid && !req_stall;

   always_comb begin
      item_in.eoi     = req_end_of_input;
      item_in.ch      = req_input_byte;
      item_in.newline = req_input_byte == 8'h0A;
      item_in.blank   = req_input_byte == 8'h20 || req_input_byte == 8'h09 ||
                        req_input_byte == 8'h0D || req_input_byte == 8'h0A ||
                        req_input_byte == 8'h00;
      item_in.semi    = req_input_byte == 8'h3B;
      item_in.lparen  = req_input_byte == 8'h28;
      item_in.rparen  = req_input_byte == 8'h29;
      item_in.dquote  = req_input_byte == 8'h22;
      item_in.squote  = req_input_byte == 8'h27;
      item_in.bslash  = req_input_byte == 8'h5C;
      valid_in = take ? 1'b1 : (cls_stall ? valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign cls_valid = valid_ff;
   assign cls_item  = item_ff;
endmodule

@@ design/sct_back.sv @@
// Lexer state machine and two-entry registered result queue whose head drives the outputs.
module sct_back #(
   parameter int unsigned MAX_TOKEN_LEN = sct_pkg::MaxTokenLen,
   parameter int unsigned MAX_POSITION  = sct_pkg::MaxPosition
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cls_valid,
   input  sct_pkg::char_class_type cls_item,
   output logic                    cls_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [3:0]              rsp_event_kind,
   output logic [15:0]             rsp_start_line,
   output logic [15:0]             rsp_start_column,
   output logic [7:0]              rsp_token_length,
   output logic                    rsp_last_of_run
);
   import sct_pkg::*;

   localparam logic [7:0]  LenCap = (MAX_TOKEN_LEN < 255) ? 8'(MAX_TOKEN_LEN) : 8'd255;
   localparam logic [15:0] PosCap = (MAX_POSITION < 65535) ? 16'(MAX_POSITION) : 16'hFFFF;

   localparam logic [2:0] M_IDLE    = 3'd0;
   localparam logic [2:0] M_COMMENT = 3'd1;
   localparam logic [2:0] M_LPAREN  = 3'd2;
   localparam logic [2:0] M_LPCOM   = 3'd3;
   localparam logic [2:0] M_SYMBOL  = 3'd4;
   localparam logic [2:0] M_STRING  = 3'd5;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] line;
      logic [15:0] col;
      logic [7:0]  len;
      logic        last;
   } result_type;

   logic [2:0]  mode_ff, mode_in;
   logic        esc_ff, esc_in;
   logic [3:0]  cls_ff, cls_in;
   logic [15:0] sline_ff, sline_in, scol_ff, scol_in, line_ff, line_in, ccol_ff, ccol_in;
   logic [7:0]  len_ff, len_in, len_inc;

   result_type  q_ff [2];
   logic [1:0]  cnt_ff, cnt_in;
   result_type  r0, r1;
   logic        v0, v1;
   logic        fire, pop, b_emit, b_mode;
   logic [15:0] col;
   logic [1:0]  nres;
   result_type  q0_in, q1_in;

   assign pop  = rsp_valid && !rsp_stall;
   assign cls_stall = (cnt_ff == 2'd2) || (cnt_ff == 2'd1 && !pop);
   assign fire = cls_valid && !cls_stall;

   assign col     = (ccol_ff < PosCap) ? ccol_ff + 16'd1 : PosCap;
   assign len_inc = (len_ff < LenCap) ? len_ff + 8'd1 : LenCap;

   always_comb begin
      mode_in  = mode_ff;
      esc_in   = esc_ff;
      cls_in   = cls_ff;
      sline_in = sline_ff;
      scol_in  = scol_ff;
      len_in   = len_ff;
      line_in  = line_ff;
      ccol_in  = ccol_ff;
      v0 = 1'b0;
      v1 = 1'b0;
      r0 = '0;
      r1 = '0;
      b_mode = 1'b0;
      if (cls_item.eoi) begin
         if (mode_ff == M_SYMBOL) begin
            v0 = 1'b1;
            r0 = '{cls_kind(cls_ff), sline_ff, scol_ff, len_ff, 1'b0};
         end else if (mode_ff == M_LPAREN || mode_ff == M_LPCOM) begin
            v0 = 1'b1;
            r0 = '{K_LPAREN, sline_ff, scol_ff, 8'd1, 1'b0};
         end
         v1 = 1'b1;
         r1 = '{K_EOF, line_ff, col, 8'd0, 1'b0};
         mode_in  = M_IDLE;
         esc_in   = 1'b0;
         cls_in   = C_START;
         sline_in = 16'd1;
         scol_in  = 16'd1;
         len_in   = 8'd0;
         line_in  = 16'd1;
         ccol_in  = 16'd0;
      end else begin
         if (cls_item.newline) begin
            line_in = (line_ff < PosCap) ? line_ff + 16'd1 : PosCap;
            ccol_in = 16'd0;
         end else begin
            ccol_in = col;
         end
         case (mode_ff)
            M_COMMENT: if (cls_item.newline) mode_in = M_IDLE;
            M_LPAREN: begin
               len_in = len_inc;
               if (cls_item.blank) begin
               end else if (cls_item.semi) begin
                  mode_in = M_LPCOM;
               end else if (cls_item.rparen) begin
                  mode_in = M_IDLE;
                  v0 = 1'b1;
                  r0 = '{K_NIL, sline_ff, scol_ff, len_inc, 1'b0};
               end else begin
                  mode_in = M_IDLE;
                  v0 = 1'b1;
                  r0 = '{K_LPAREN, sline_ff, scol_ff, 8'd1, 1'b0};
                  b_mode = 1'b1;
               end
            end
            M_LPCOM: begin
               len_in = len_inc;
               if (cls_item.newline) mode_in = M_LPAREN;
            end
            M_SYMBOL: begin
               if (cls_item.blank || cls_item.lparen || cls_item.rparen ||
                   cls_item.dquote || cls_item.squote || cls_item.semi) begin
                  v0 = 1'b1;
                  r0 = '{cls_kind(cls_ff), sline_ff, scol_ff, len_ff, 1'b0};
                  mode_in = M_IDLE;
                  cls_in  = C_START;
                  b_mode  = 1'b1;
               end else begin
                  len_in = len_inc;
                  cls_in = cls_next(cls_ff, cls_item.ch);
               end
            end
            M_STRING: begin
               if (cls_item.newline) begin
                  v0 = 1'b1;
                  r0 = '{K_UNCLOSED, line_ff, col, 8'd0, 1'b0};
                  mode_in = M_IDLE;
                  esc_in  = 1'b0;
               end else begin
                  len_in = len_inc;
                  if (cls_item.dquote && !esc_ff) begin
                     v0 = 1'b1;
                     r0 = '{K_STRING, sline_ff, scol_ff, len_inc, 1'b0};
                     mode_in = M_IDLE;
                  end else begin
                     esc_in = cls_item.bslash;
                  end
               end
            end
            default: begin
               mode_in = M_IDLE;
               b_mode  = 1'b1;
            end
         endcase
         if (b_mode) begin
            if (cls_item.blank) begin
            end else if (cls_item.semi) begin
               mode_in = M_COMMENT;
            end else if (cls_item.rparen || cls_item.squote) begin
               v1 = 1'b1;
               r1 = '{cls_item.rparen ? K_RPAREN : K_QUOTE, line_ff, col, 8'd1, 1'b0};
            end else begin
               sline_in = line_ff;
               scol_in  = col;
               len_in   = 8'd1;
               if (cls_item.lparen) begin
                  mode_in = M_LPAREN;
               end else if (cls_item.dquote) begin
                  mode_in = M_STRING;
                  esc_in  = 1'b0;
               end else begin
                  mode_in = M_SYMBOL;
                  cls_in  = cls_next(C_START, cls_item.ch);
               end
            end
         end
      end
      if (v1) begin
         r1.last = 1'b1;
      end else begin
         r0.last = 1'b1;
      end
   end

   // Compact the emitted results into the queue behind what is still held.
   always_comb begin
      result_type a, b;
      a = v0 ? r0 : r1;
      b = r1;
      nres = fire ? (2'(v0) + 2'(v1)) : 2'd0;
      q0_in = q_ff[0];
      q1_in = q_ff[1];
      if (pop) begin
         q0_in = q_ff[1];
      end
      cnt_in = cnt_ff - 2'(pop) + nres;
      if (nres != 2'd0) begin
         if ((cnt_ff - 2'(pop)) == 2'd0) begin
            q0_in = a;
            q1_in = b;
         end else begin
            q1_in = a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         esc_ff   <= 1'b0;
         cls_ff   <= C_START;
         sline_ff <= 16'd1;
         scol_ff  <= 16'd1;
         len_ff   <= 8'd0;
         line_ff  <= 16'd1;
         ccol_ff  <= 16'd0;
         cnt_ff   <= 2'd0;
      end else begin
         if (fire) begin
            mode_ff  <= mode_in;
            esc_ff   <= esc_in;
            cls_ff   <= cls_in;
            sline_ff <= sline_in;
            scol_ff  <= scol_in;
            len_ff   <= len_in;
            line_ff  <= line_in;
            ccol_ff  <= ccol_in;
         end
         cnt_ff <= cnt_in;
      end
      q_ff[0] <= q0_in;
      q_ff[1] <= q1_in;
   end

   assign b_emit           = cnt_ff != 2'd0;
   assign rsp_valid        = b_emit;
   assign rsp_event_kind   = q_ff[0].kind;
   assign rsp_start_line   = q_ff[0].line;
   assign rsp_start_column = q_ff[0].col;
   assign rsp_token_length = q_ff[0].len;
   assign rsp_last_of_run  = q_ff[0].last;

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("result queue overflow");
   a_no_fire_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !fire)
      else $error("item taken while queue full");
   a_eof_resets: assert property (@(posedge clock) disable iff (reset)
      fire && cls_item.eoi |=> mode_ff == M_IDLE && line_ff == 16'd1)
      else $error("end of input did not reset lexer");
`endif
endmodule

@@ design/sexpr_char_tokenizer.sv @@
// Top level of the S-expression character tokenizer.
// Results pass through the input register and then the result queue.
// Throughput: one item per cycle while each item yields at most one result and the receiver does not stall;
// an item yielding two results fills the queue and holds input until a result is taken.
// Reset: synchronous, active high; clears lexer state, position and queue.
module sexpr_char_tokenizer #(
   parameter int unsigned MAX_TOKEN_LEN = sct_pkg::MaxTokenLen,
   parameter int unsigned MAX_POSITION  = sct_pkg::MaxPosition
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_input_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_event_kind,
   output logic [15:0] rsp_start_line,
   output logic [15:0] rsp_start_column,
   output logic [7:0]  rsp_token_length,
   output logic        rsp_last_of_run
);
   import sct_pkg::*;

   logic           cls_valid, cls_stall;
   char_class_type cls_item;

   sct_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_input_byte, .req_end_of_input,
      .cls_valid, .cls_item, .cls_stall
   );

   sct_back #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN), .MAX_POSITION(MAX_POSITION)) u_back (
      .clock, .reset, .cls_valid, .cls_item, .cls_stall,
      .rsp_valid, .rsp_stall, .rsp_event_kind, .rsp_start_line,
      .rsp_start_column, .rsp_token_length, .rsp_last_of_run
   );
endmodule

@@ tb/sv/sexpr_char_tokenizer_tb.sv @@
// Self-checking testbench for the S-expression character tokenizer.
module sexpr_char_tokenizer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sct_pkg::*;

   typedef struct {
      logic [3:0]  kind;
      logic [15:0] line;
      logic [15:0] column;
      logic [7:0]  length;
      logic        last;
   } token_desc_type;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_COMMENT, MODE_LPAREN, MODE_LPAREN_COMMENT, MODE_SYMBOL, MODE_STRING
   } lex_mode_type;

   class token_scoreboard;
      lex_mode_type   mode;
      logic           escaped;
      logic [3:0]     atom_class;
      logic [15:0]    tok_line, tok_column, cur_line, cur_column;
      logic [7:0]     tok_length;
      token_desc_type pending_tokens[$];
      int             errors, checked;
      int             kind_seen[16];

      function void clear();
         mode = MODE_IDLE;
         escaped = 1'b0;
         atom_class = C_START;
         tok_line = 16'd1;
         tok_column = 16'd1;
         tok_length = 8'd0;
         cur_line = 16'd1;
         cur_column = 16'd0;
      endfunction

      function void emit(logic [3:0] k, logic [15:0] l, logic [15:0] c, logic [7:0] n);
         token_desc_type t;
         t.kind = k;
         t.line = l;
         t.column = c;
         t.length = n;
         t.last = 1'b0;
         pending_tokens = {pending_tokens, t};
      endfunction

      function logic [7:0] bump(logic [7:0] n);
         return (n < 8'd255) ? n + 8'd1 : n;
      endfunction

      function logic is_blank(logic [7:0] c);
         return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A || c == 8'h00;
      endfunction

      function logic is_separator(logic [7:0] c);
         return is_blank(c) || c == "(" || c == ")" || c == 8'h22 || c == 8'h27 || c == ";";
      endfunction

      function logic [3:0] next_class(logic [3:0] s, logic [7:0] c);
         logic dig;
         dig = c >= "0" && c <= "9";
         case (s)
            C_START: begin
               if (dig) return C_INT;
               if (c == "+" || c == "-") return C_SIGN;
               if (c == ".") return C_DOT;
               if (c == "t") return C_LT;
               if (c == "#") return C_HASH;
               if (c == "n") return C_N1;
            end
            C_SIGN: begin
               if (dig) return C_INT;
               if (c == ".") return C_SIGNDOT;
            end
            C_INT: begin
               if (dig) return C_INT;
               if (c == ".") return C_INTDOT;
            end
            C_DOT, C_SIGNDOT, C_INTDOT, C_FRAC: begin
               if (dig) return C_FRAC;
               if (c == "f") return C_FEND;
            end
            C_HASH: begin
               if (c == "t") return C_HT;
               if (c == "f") return C_HF;
            end
            C_N1: if (c == "i") return C_N2;
            C_N2: if (c == "l") return C_N3;
            default: ;
         endcase
         return C_OTHER;
      endfunction

      function logic [3:0] atom_kind(logic [3:0] s);
         case (s)
            C_DOT: return K_DOT;
            C_LT, C_HT: return K_TRUE;
            C_HF, C_N3: return K_NIL;
            C_INT: return K_INT;
            C_INTDOT, C_FRAC, C_FEND: return K_FLOAT;
            default: return K_SYMBOL;
         endcase
      endfunction

      function void start_token(logic [7:0] c, logic [15:0] l, logic [15:0] col);
         if (is_blank(c)) return;
         if (c == ";") begin
            mode = MODE_COMMENT;
            return;
         end
         if (c == ")") begin
            emit(K_RPAREN, l, col, 8'd1);
            return;
         end
         if (c == 8'h27) begin
            emit(K_QUOTE, l, col, 8'd1);
            return;
         end
         tok_line = l;
         tok_column = col;
         tok_length = 8'd1;
         if (c == "(") mode = MODE_LPAREN;
         else if (c == 8'h22) begin
            mode = MODE_STRING;
            escaped = 1'b0;
         end else begin
            mode = MODE_SYMBOL;
            atom_class = next_class(C_START, c);
         end
      endfunction

      function void note_input(logic [7:0] c, logic eoi);
         logic [15:0] col, l;
         int prior_count;
         prior_count = pending_tokens.size();
         col = (cur_column < 16'hFFFF) ? cur_column + 16'd1 : cur_column;
         l = cur_line;
         if (eoi) begin
            if (mode == MODE_SYMBOL) emit(atom_kind(atom_class), tok_line, tok_column, tok_length);
            else if (mode == MODE_LPAREN || mode == MODE_LPAREN_COMMENT)
               emit(K_LPAREN, tok_line, tok_column, 8'd1);
            emit(K_EOF, l, col, 8'd0);
            clear();
         end else begin
            if (c == 8'h0A) begin
               if (cur_line < 16'hFFFF) cur_line++;
               cur_column = 16'd0;
            end else cur_column = col;
            case (mode)
               MODE_COMMENT: if (c == 8'h0A) mode = MODE_IDLE;
               MODE_LPAREN: begin
                  tok_length = bump(tok_length);
                  if (c == ";") mode = MODE_LPAREN_COMMENT;
                  else if (!is_blank(c)) begin
                     mode = MODE_IDLE;
                     if (c == ")") emit(K_NIL, tok_line, tok_column, tok_length);
                     else begin
                        emit(K_LPAREN, tok_line, tok_column, 8'd1);
                        start_token(c, l, col);
                     end
                  end
               end
               MODE_LPAREN_COMMENT: begin
                  tok_length = bump(tok_length);
                  if (c == 8'h0A) mode = MODE_LPAREN;
               end
               MODE_SYMBOL: begin
                  if (is_separator(c)) begin
                     emit(atom_kind(atom_class), tok_line, tok_column, tok_length);
                     mode = MODE_IDLE;
                     atom_class = C_START;
                     start_token(c, l, col);
                  end else begin
                     tok_length = bump(tok_length);
                     atom_class = next_class(atom_class, c);
                  end
               end
               MODE_STRING: begin
                  if (c == 8'h0A) begin
                     emit(K_UNCLOSED, l, col, 8'd0);
                     mode = MODE_IDLE;
                     escaped = 1'b0;
                  end else begin
                     tok_length = bump(tok_length);
                     if (c == 8'h22 && !escaped) begin
                        emit(K_STRING, tok_line, tok_column, tok_length);
                        mode = MODE_IDLE;
                     end else escaped = (c == 8'h5C);
                  end
               end
               default: begin
                  mode = MODE_IDLE;
                  start_token(c, l, col);
               end
            endcase
         end
         if (pending_tokens.size() > prior_count) pending_tokens[$].last = 1'b1;
      endfunction

      function void check_result(token_desc_type got);
         token_desc_type exp;
         if (pending_tokens.size() == 0) begin
            $error("unexpected result: kind %0d line %0d column %0d", got.kind, got.line,
                   got.column);
            errors++;
            return;
         end
         exp = pending_tokens.pop_front();
         checked++;
         kind_seen[exp.kind]++;
         if (got.kind !== exp.kind) begin
            $error("event_kind: expected %0d, got %0d", exp.kind, got.kind);
            errors++;
         end
         if (got.line !== exp.line) begin
            $error("start_line: expected %0d, got %0d", exp.line, got.line);
            errors++;
         end
         if (got.column !== exp.column) begin
            $error("start_column: expected %0d, got %0d", exp.column, got.column);
            errors++;
         end
         if (got.length !== exp.length) begin
            $error("token_length: expected %0d, got %0d", exp.length, got.length);
            errors++;
         end
         if (got.last !== exp.last) begin
            $error("last_of_run: expected %0d, got %0d", exp.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [7:0]  req_input_byte = 0;
   logic        req_end_of_input = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [3:0]  rsp_event_kind;
   logic [15:0] rsp_start_line, rsp_start_column;
   logic [7:0]  rsp_token_length;
   logic        rsp_last_of_run;

   token_scoreboard lexer_model = new();
   int  chars_sent = 0;
   int  idle_cycles = 0;
   bit  quiet_phase = 0;
   bit  long_hold = 0;

   sexpr_char_tokenizer dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Send one item, with an optional burst of idle cycles first.
   task automatic send_char(logic [7:0] c, logic eoi);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1;
      req_input_byte <= c;
      req_end_of_input <= eoi;
      do @(posedge clock); while (req_stall);
      lexer_model.note_input(c, eoi);
      chars_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
   endtask

   function automatic logic [7:0] random_char();
      case ($urandom_range(0, 15))
         0: return " ";
         1: return 8'h0A;
         2: return "(";
         3: return ")";
         4: return 8'h22;
         5: return 8'h27;
         6: return ";";
         7: return 8'h5C;
         8: return ".";
         9: return "#";
         10, 11: return 8'($urandom_range(8'h30, 8'h39));
         12: return ($urandom_range(0, 1)) ? "-" : "+";
         13: return 8'($urandom_range(0, 255));
         default: begin
            case ($urandom_range(0, 4))
               0: return "t";
               1: return "f";
               2: return "n";
               3: return "i";
               default: return "l";
            endcase
         end
      endcase
   endfunction

   task automatic send_random_form();
      case ($urandom_range(0, 9))
         0: send_text("( )");
         1: send_text("(;c\n)");
         2: send_text("\"a\\\"b\" ");
         3: send_text("-12.5f ");
         4: send_text("nil #t #f t . ");
         5: send_text("\"open\n");
         default: repeat ($urandom_range(1, 8)) send_char(random_char(), 1'b0);
      endcase
   endtask

   // Receiver: random stall bursts, one long hold, none in the final stretch.
   initial begin
      rsp_stall <= 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (60) @(posedge clock);
            rsp_stall <= 0;
            long_hold = 0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         token_desc_type got;
         got.kind = rsp_event_kind;
         got.line = rsp_start_line;
         got.column = rsp_start_column;
         got.length = rsp_token_length;
         got.last = rsp_last_of_run;
         lexer_model.check_result(got);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      lexer_model.clear();
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_text("( ) (;x\n) 'a \"s\\\"q\" . t #t #f nil 12 -3.5 +.5f 1.f - + .");
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_text(" \"bad\n(abc");
      send_char(8'h00, 1'b1);
      send_text("(");
      send_char(8'h55, 1'b1);
      long_hold = 1;
      repeat (40) send_char(random_char(), 1'b0);
      while (chars_sent < 1250) begin
         send_random_form();
         if ($urandom_range(0, 30) == 0) send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      repeat (300) send_char("x", 1'b0);
      send_char(" ", 1'b0);
      quiet_phase = 1;
      while (chars_sent < 1550) send_random_form();
      send_char(8'h00, 1'b1);
      req_valid <= 0;
      while (lexer_model.pending_tokens.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d characters, checked %0d tokens (%0d nil, %0d float, %0d unclosed).",
               chars_sent, lexer_model.checked, lexer_model.kind_seen[K_NIL],
               lexer_model.kind_seen[K_FLOAT], lexer_model.kind_seen[K_UNCLOSED]);
      if (lexer_model.errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
